/* rtl/u8u16_pkg.sv */
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// Used by u8u16_front, u8u16_queue, u8u16_back and the top level.
// No dependencies.
package u8u16_pkg;

	localparam int unsigned UNIT_W        = 21;
	localparam int unsigned LOW_W         = 10;
	localparam int unsigned QUEUE_DEPTH   = 4;

	localparam logic [UNIT_W-1:0] MAX_SCALAR = 21'h10FFFF;
	localparam logic [UNIT_W-1:0] SURR_FIRST = 21'h00D800;
	localparam logic [UNIT_W-1:0] SURR_LAST  = 21'h00DFFF;
	localparam logic [UNIT_W-1:0] SUPP_FIRST = 21'h010000;

	// Upper six bits of the high and low surrogate ranges
	localparam logic [5:0] HI_SURR_TAG = 6'b110110;
	localparam logic [5:0] LO_SURR_TAG = 6'b110111;

	// One queued record: a single unit, a surrogate pair, or an error marker
	typedef struct packed {
		logic              pair;
		logic [UNIT_W-1:0] unit0;
		logic [LOW_W-1:0]  unit1;
		logic              err;
		logic              last;
	} entry_t;

	// Smallest scalar allowed for a sequence of the given length
	function automatic logic [UNIT_W-1:0] min_for_len(input logic [2:0] len);
		logic [UNIT_W-1:0] m;
		case (len)
			3'd2:    m = 21'h000080;
			3'd3:    m = 21'h000800;
			3'd4:    m = 21'h010000;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

/* rtl/utf8_to_utf16_decoder.sv */
// Validating UTF-8 decoder with UTF-16 or code point output.
// Input channel: in_valid/in_ready carry one beat per byte (data_byte,
// end_of_string). Output channel: out_valid/out_ready carry one result beat
// (code_unit, decode_error, last_of_string). Config channel: cfg_valid/
// cfg_ready write cfg_data[0] as the output mode (1 = UTF-16, reset 1);
// cfg_ready is always high.
// Throughput: one input byte per cycle while the queue has room; one result
// beat per cycle while out_ready is high, so a surrogate pair gives two beats.
// The record queue between front and back end absorbs the difference.
// The completing byte writes its record into the queue when accepted; the
// back end then loads it into the output register, which drives the beat.
// A receiver stall holds the output register; the queue fills and in_ready
// drops once QueueDepth records wait. An invalid string gives one error beat
// (code_unit 0, decode_error 1, last_of_string 1) at its final byte.
// Reset clears sequence state, empties the queue, clears output valid and sets UTF-16 mode.
// Depends on u8u16_pkg, u8u16_front, u8u16_queue, u8u16_back.
module utf8_to_utf16_decoder #(
	parameter int unsigned QueueDepth = u8u16_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   data_byte,
	input  logic                         end_of_string,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [u8u16_pkg::UNIT_W-1:0] code_unit,
	output logic                         decode_error,
	output logic                         last_of_string
);

	logic              mode_q;
	logic              wr_en;
	u8u16_pkg::entry_t wr_entry;
	logic              q_full;
	logic              q_pop;
	logic              q_valid;
	u8u16_pkg::entry_t q_entry;

	assign cfg_ready = 1'b1;

	// Output mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	u8u16_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_string (end_of_string),
		.utf16_mode    (mode_q),
		.q_full        (q_full),
		.wr_en         (wr_en),
		.wr_entry      (wr_entry)
	);

	u8u16_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_entry (wr_entry),
		.full     (q_full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_entry (q_entry)
	);

	u8u16_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_entry        (q_entry),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.code_unit      (code_unit),
		.decode_error   (decode_error),
		.last_of_string (last_of_string)
	);

endmodule

/* rtl/u8u16_front.sv */
// Front end: accepts UTF-8 bytes, tracks sequence state, validates scalars
// and writes finished records into the queue. Depends on u8u16_pkg.
module u8u16_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_string,
	input  logic                  utf16_mode,
	input  logic                  q_full,
	output logic                  wr_en,
	output u8u16_pkg::entry_t     wr_entry
);

	logic [u8u16_pkg::UNIT_W-1:0] partial_q, partial_d;
	logic [1:0]                   pend_q, pend_d;
	logic [2:0]                   len_q, len_d;
	logic                         err_q, err_d;

	logic                         accept;
	logic                         complete;
	logic                         bad_scalar;
	logic [u8u16_pkg::UNIT_W-1:0] cp;
	logic [19:0]                  v;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Byte decode, scalar check and record build
	always_comb begin
		partial_d  = partial_q;
		pend_d     = pend_q;
		len_d      = len_q;
		err_d      = err_q;
		complete   = 1'b0;
		bad_scalar = 1'b0;
		wr_en      = 1'b0;
		wr_entry   = '0;
		cp         = '0;
		v          = '0;

		if (!err_q) begin
			if (pend_q == 2'd0) begin
				if (data_byte[7] == 1'b0) begin
					partial_d = {13'd0, data_byte};
					len_d     = 3'd1;
					complete  = 1'b1;
				end else if (data_byte[7:5] == 3'b110) begin
					partial_d = {16'd0, data_byte[4:0]};
					pend_d    = 2'd1;
					len_d     = 3'd2;
				end else if (data_byte[7:4] == 4'b1110) begin
					partial_d = {17'd0, data_byte[3:0]};
					pend_d    = 2'd2;
					len_d     = 3'd3;
				end else if (data_byte[7:3] == 5'b11110) begin
					partial_d = {18'd0, data_byte[2:0]};
					pend_d    = 2'd3;
					len_d     = 3'd4;
				end else begin
					err_d = 1'b1;
				end
			end else if (data_byte[7:6] != 2'b10) begin
				err_d = 1'b1;
			end else begin
				partial_d = {partial_q[u8u16_pkg::UNIT_W-7:0], data_byte[5:0]};
				pend_d    = pend_q - 2'd1;
				complete  = (pend_q == 2'd1);
			end

			if (complete) begin
				cp         = partial_d;
				bad_scalar = (cp < u8u16_pkg::min_for_len(len_d))
					|| (cp > u8u16_pkg::MAX_SCALAR)
					|| ((cp >= u8u16_pkg::SURR_FIRST) && (cp <= u8u16_pkg::SURR_LAST));
				v          = 20'(cp - u8u16_pkg::SUPP_FIRST);
				if (bad_scalar) begin
					err_d = 1'b1;
				end else if (utf16_mode && (cp >= u8u16_pkg::SUPP_FIRST)) begin
					wr_en          = 1'b1;
					wr_entry.pair  = 1'b1;
					wr_entry.unit0 = {5'd0, u8u16_pkg::HI_SURR_TAG, v[19:10]};
					wr_entry.unit1 = v[9:0];
					wr_entry.last  = end_of_string;
				end else begin
					wr_en          = 1'b1;
					wr_entry.unit0 = cp;
					wr_entry.last  = end_of_string;
				end
				partial_d = '0;
				len_d     = 3'd1;
			end

			// Truncated sequence at end of string
			if (end_of_string && !err_d && (pend_d != 2'd0)) begin
				err_d = 1'b1;
			end
		end

		if (end_of_string) begin
			if (err_d) begin
				wr_en    = 1'b1;
				wr_entry = '0;
				wr_entry.err  = 1'b1;
				wr_entry.last = 1'b1;
			end
			partial_d = '0;
			pend_d    = 2'd0;
			len_d     = 3'd1;
			err_d     = 1'b0;
		end

		if (!accept) begin
			wr_en = 1'b0;
		end
	end

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pend_q    <= 2'd0;
			len_q     <= 3'd1;
			err_q     <= 1'b0;
		end else if (accept) begin
			partial_q <= partial_d;
			pend_q    <= pend_d;
			len_q     <= len_d;
			err_q     <= err_d;
		end
	end

endmodule

/* rtl/u8u16_queue.sv */
// Short FIFO of decoded records between front and back end.
// Depends on u8u16_pkg for the record type.
module u8u16_queue #(
	parameter int unsigned Depth = u8u16_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  u8u16_pkg::entry_t wr_entry,
	output logic              full,
	input  logic              rd_en,
	output logic              rd_valid,
	output u8u16_pkg::entry_t rd_entry
);

	localparam int unsigned PtrW = $clog2(Depth);
	localparam int unsigned CntW = $clog2(Depth + 1);

	u8u16_pkg::entry_t mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_wr, do_rd;

	assign full     = (count_q == CntW'(Depth));
	assign rd_valid = (count_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count; pointers wrap at the last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/u8u16_back.sv */
// Back end: splits queued records into result beats, one per cycle while the
// receiver is ready, through an output register. Depends on u8u16_pkg.
module u8u16_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  u8u16_pkg::entry_t            q_entry,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [u8u16_pkg::UNIT_W-1:0] code_unit,
	output logic                         decode_error,
	output logic                         last_of_string
);

	logic                         out_valid_q;
	logic [u8u16_pkg::UNIT_W-1:0] unit_q;
	logic                         err_q;
	logic                         last_q;
	logic                         half_q;
	logic                         load;
	logic                         first_half;

	assign load       = q_valid && (!out_valid_q || out_ready);
	assign first_half = q_entry.pair && !half_q;
	assign q_pop      = load && !first_half;

	assign out_valid      = out_valid_q;
	assign code_unit      = unit_q;
	assign decode_error   = err_q;
	assign last_of_string = last_q;

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (first_half) begin
				unit_q <= q_entry.unit0;
				err_q  <= 1'b0;
				last_q <= 1'b0;
			end else begin
				unit_q <= half_q ? {5'd0, u8u16_pkg::LO_SURR_TAG, q_entry.unit1}
					: q_entry.unit0;
				err_q  <= q_entry.err;
				last_q <= q_entry.last;
			end
		end
	end

	// Output valid and pair phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			half_q      <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				half_q      <= first_half;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
